>>> rtl/core/eepq_pkg.sv
// Shared types, constants and helpers for the EEPROM posted-write queue.
package eepq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ARRAY_BYTES = 1024;

  localparam int OP_W    = 3;
  localparam int ADDR_W  = 10;
  localparam int DATA_W  = 8;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 6;

  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int AIDX_W = $clog2(ARRAY_BYTES);

  // input tdata layout
  localparam int IN_ADDR_LSB = 0;
  localparam int IN_DATA_LSB = IN_ADDR_LSB + ADDR_W;
  localparam int IN_BITS     = IN_DATA_LSB + DATA_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_RD_LSB    = 0;
  localparam int OUT_STAT_LSB  = OUT_RD_LSB + DATA_W;
  localparam int OUT_COUNT_LSB = OUT_STAT_LSB + STAT_W;
  localparam int OUT_DRAIN_BIT = OUT_COUNT_LSB + COUNT_W;
  localparam int OUT_BITS      = OUT_DRAIN_BIT + 1;
  localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_POST  = 3'd0,
    OP_READY = 3'd1,
    OP_READ  = 3'd2,
    OP_ERASE = 3'd3,
    OP_WRITE = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } q_entry_t;

  // array port request: one read and one write per cycle
  typedef struct packed {
    logic              re;
    logic [AIDX_W-1:0] raddr;
    logic              we;
    logic [AIDX_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
  } arr_req_t;

  function automatic logic [QIDX_W-1:0] next_slot(input logic [QIDX_W-1:0] idx);
    return (idx == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic in_range(input logic [ADDR_W-1:0] addr);
    return 32'(addr) < ARRAY_BYTES;
  endfunction

endpackage

>>> rtl/core/eepq_array.sv
// EEPROM byte array memory with a post-reset erase sweep.
module eepq_array
  import eepq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  arr_req_t          req,
  output logic [DATA_W-1:0] rdata,
  output logic              busy
);

  logic [DATA_W-1:0] mem [ARRAY_BYTES];
  logic [AIDX_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AIDX_W'(ARRAY_BYTES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= ERASED_BYTE;
    end else if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

>>> rtl/core/eeprom_posted_write_queue.sv
// Top level: EEPROM byte array behind a circular posted-write queue.
//
// Each transaction has an accept cycle that issues reads of the queue memory
// (at the tail slot) and the byte array (at the item's address), and an execute cycle that
// uses the registered read data, writes back to either memory and loads the result register.
// Both memories register their read data; a stalled result holds the execute cycle until it is
// taken. After reset the array is swept to 0xFF, one byte a cycle,
// over ARRAY_BYTES (1024) bytes; s_tready stays low during the sweep. The queue holds at most
// QUEUE_DEPTH-1 entries; a post to a full queue is refused with status 1.
module eeprom_posted_write_queue
  import eepq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // address[9:0], data[17:10], zero pad
  input  logic [OP_W-1:0]        s_tuser,   // operation[2:0]
  input  logic                   s_tlast,   // block_last
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // read_data[7:0], status[9:8],
                                            // queue_count[15:10], draining[16], zero pad
);

  state_t state, state_next;

  // accepted transaction
  op_t               op;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] data;
  logic              last;

  logic [QIDX_W-1:0] head, head_next;
  logic [QIDX_W-1:0] tail, tail_next;
  logic [QIDX_W-1:0] count, count_next;
  logic              drain, drain_next;

  q_entry_t          qmem [QUEUE_DEPTH];
  q_entry_t          q_rd;
  logic              q_we;

  arr_req_t          arr_req;
  logic [DATA_W-1:0] arr_rdata;
  logic              arr_busy;

  logic              accept;
  logic              go;
  logic [DATA_W-1:0] res_rd;
  status_t           res_st;

  logic [DATA_W-1:0] out_rd;
  status_t           out_st;
  logic [QIDX_W-1:0] out_count;
  logic              out_drain;

  eepq_array u_array (
    .clk   (clk),
    .rst   (rst),
    .req   (arr_req),
    .rdata (arr_rdata),
    .busy  (arr_busy)
  );

  assign s_tready = (state == S_IDLE) && !arr_busy;
  assign accept   = s_tvalid && s_tready;
  assign go       = (state == S_EXEC) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      drain <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      drain <= drain_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= op_t'(s_tuser);
      addr <= s_tdata[IN_ADDR_LSB +: ADDR_W];
      data <= s_tdata[IN_DATA_LSB +: DATA_W];
      last <= s_tlast;
      q_rd <= qmem[tail];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[head] <= '{addr: addr, data: data};
    end
  end

  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    drain_next = drain;
    q_we       = 1'b0;
    res_rd     = '0;
    res_st     = STAT_OK;

    arr_req.re    = accept;
    arr_req.raddr = AIDX_W'(s_tdata[IN_ADDR_LSB +: ADDR_W]);
    arr_req.we    = 1'b0;
    arr_req.waddr = AIDX_W'(addr);
    arr_req.wdata = data;

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op)
          OP_POST: begin
            if (!in_range(addr)) begin
              res_st = STAT_RANGE;
            end else if (count >= QIDX_W'(QUEUE_DEPTH - 1)) begin
              res_st     = STAT_FULL;
              drain_next = 1'b1;
            end else begin
              q_we       = go;
              head_next  = next_slot(head);
              count_next = count + 1'b1;
              if (last || (count + 1'b1 >= QIDX_W'(QUEUE_DEPTH - 1))) begin
                drain_next = 1'b1;
              end
            end
          end
          OP_READY: begin
            if (count == '0) begin
              drain_next = 1'b0;
            end else begin
              arr_req.we    = go && in_range(q_rd.addr);
              arr_req.waddr = AIDX_W'(q_rd.addr);
              arr_req.wdata = q_rd.data;
              tail_next     = next_slot(tail);
              count_next    = count - 1'b1;
            end
          end
          OP_READ: begin
            if (in_range(addr)) begin
              res_rd = arr_rdata;
            end else begin
              res_st = STAT_RANGE;
            end
          end
          OP_ERASE: begin
            if (in_range(addr)) begin
              arr_req.we    = go;
              arr_req.wdata = ERASED_BYTE;
            end else begin
              res_st = STAT_RANGE;
            end
          end
          OP_WRITE: begin
            if (in_range(addr)) begin
              arr_req.we = go;
            end else begin
              res_st = STAT_RANGE;
            end
          end
          default: begin
          end
        endcase
        // hold everything until the result register frees up
        if (go) begin
          state_next = S_IDLE;
        end else begin
          head_next  = head;
          tail_next  = tail;
          count_next = count;
          drain_next = drain;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_rd    <= res_rd;
      out_st    <= res_st;
      out_count <= count_next;
      out_drain <= drain_next;
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[OUT_RD_LSB +: DATA_W]     = out_rd;
    m_tdata[OUT_STAT_LSB +: STAT_W]   = out_st;
    m_tdata[OUT_COUNT_LSB +: COUNT_W] = COUNT_W'(out_count);
    m_tdata[OUT_DRAIN_BIT]            = out_drain;
  end

endmodule

>>> rtl/core/eepq_check.sv
// Port-level checker for the EEPROM posted-write queue, bound to the top level.
module eepq_check
  import eepq_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [STAT_W-1:0]  st;
  logic [DATA_W-1:0]  rd;
  logic [COUNT_W-1:0] cnt;

  assign st  = m_tdata[OUT_STAT_LSB +: STAT_W];
  assign rd  = m_tdata[OUT_RD_LSB +: DATA_W];
  assign cnt = m_tdata[OUT_COUNT_LSB +: COUNT_W];

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one transaction in flight: no accept on the following cycle
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("back-to-back accept");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (st == STAT_OK) || (st == STAT_FULL) || (st == STAT_RANGE))
    else $error("undefined status code");

  a_rd_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (rd != '0) |-> st == STAT_OK)
    else $error("read data on failed transaction");

  // a refused post means a full queue with draining on
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st == STAT_FULL) |->
      m_tdata[OUT_DRAIN_BIT] && (cnt == COUNT_W'(QUEUE_DEPTH - 1)))
    else $error("full status without full queue");

endmodule

bind eeprom_posted_write_queue eepq_check u_eepq_check (.*);
